### design/gae_pkg.sv
// shared types, constants and saturation helper for the advantage engine
`default_nettype none

package gae_pkg;

  localparam int VAL_W    = 32;
  localparam int FRAC_W   = 16;
  localparam int FAC_W    = 17;
  localparam int GL_W     = FAC_W + 1;
  localparam int WIDE_W   = VAL_W + GL_W + 1;
  localparam int KIND_W   = 2;
  localparam int STAT_W   = 2;
  localparam int ROW_W    = 6;
  localparam int CFG_IDX_W = 2;
  localparam int ROW_BITS = 3 * VAL_W + 2;

  localparam int CAPACITY_DEF = 64;

  localparam logic [FAC_W-1:0] DISCOUNT_RST    = 17'd64881;
  localparam logic [FAC_W-1:0] TRACE_DECAY_RST = 17'd62259;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFFFFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;

  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACE_DECAY = 2'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_FINISH = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BOOT,
    ST_TRACE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic add_req;
    logic fin_start;
    logic fin_empty;
    logic clear;
    logic mul_boot;
    logic mul_trace;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic last;
  } dp_stat_t;

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-VAL_W:0] hi;
    hi = v[WIDE_W-1:VAL_W-1];
    if (&hi || ~|hi) begin
      sat_val = v[VAL_W-1:0];
    end else if (v[WIDE_W-1]) begin
      sat_val = VAL_MIN;
    end else begin
      sat_val = VAL_MAX;
    end
  endfunction

endpackage

`default_nettype wire

### design/gae_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module gae_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### design/gae_ctrl.sv
// controller state machine for the advantage engine
`default_nettype none

module gae_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [gae_pkg::KIND_W-1:0] in_kind,
  input  gae_pkg::dp_stat_t         stat,
  output gae_pkg::ctrl_cmd_t        cmd,
  output logic                      busy
);

  import gae_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_kind)
            KIND_ADD: cmd.add_req = 1'b1;
            KIND_FINISH: begin
              if (stat.empty) begin
                cmd.fin_empty = 1'b1;
              end else begin
                cmd.fin_start = 1'b1;
                state_nxt     = ST_BOOT;
              end
            end
            KIND_CLEAR: cmd.clear = 1'b1;
            default: ;
          endcase
        end
      end
      ST_BOOT: begin
        cmd.mul_boot = 1'b1;
        state_nxt    = ST_TRACE;
      end
      ST_TRACE: begin
        cmd.mul_trace = 1'b1;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = stat.last ? ST_IDLE : ST_BOOT;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  a_boot_to_trace: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BOOT |=> state_r == ST_TRACE)
    else $error("boot phase not followed by trace phase");

  a_trace_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_TRACE |=> state_r == ST_EMIT)
    else $error("trace phase not followed by emit phase");

  a_walk_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && !stat.last) |=> state_r == ST_BOOT)
    else $error("walk stopped before row zero");

endmodule

`default_nettype wire

### design/gae_dp.sv
// datapath: rollout store, shared multiplier, trace recursion and result register
`default_nettype none

module gae_dp #(
  parameter int CAPACITY = gae_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gae_pkg::ctrl_cmd_t                  cmd,
  output gae_pkg::dp_stat_t                   stat,
  input  logic                                cfg_we,
  input  logic [gae_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gae_pkg::FAC_W-1:0]           cfg_data,
  input  logic signed [gae_pkg::VAL_W-1:0]    in_reward,
  input  logic signed [gae_pkg::VAL_W-1:0]    in_state_value,
  input  logic signed [gae_pkg::VAL_W-1:0]    in_successor_value,
  input  logic                                in_terminated,
  input  logic                                in_truncated,
  input  logic signed [gae_pkg::VAL_W-1:0]    in_tail_value,
  output logic                                out_valid,
  output logic [gae_pkg::STAT_W-1:0]          out_status,
  output logic [gae_pkg::ROW_W-1:0]           out_row_index,
  output logic signed [gae_pkg::VAL_W-1:0]    out_advantage,
  output logic signed [gae_pkg::VAL_W-1:0]    out_target_return,
  output logic                                out_last_in_run
);

  import gae_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // config and control state
  logic [FAC_W-1:0]        discount_r;
  logic [FAC_W-1:0]        trace_decay_r;
  logic [CW-1:0]           count_r;
  logic signed [VAL_W-1:0] trace_acc_r;
  logic                    out_valid_r;

  // walk and payload registers
  logic [AW-1:0]           t_r;
  logic [GL_W-1:0]         gl_r;
  logic signed [VAL_W-1:0] next_val_r;
  logic signed [VAL_W-1:0] sb_r;
  logic signed [VAL_W-1:0] sg_r;
  logic signed [VAL_W-1:0] delta_r;
  logic [STAT_W-1:0]       out_status_r;
  logic [ROW_W-1:0]        out_row_index_r;
  logic signed [VAL_W-1:0] out_advantage_r;
  logic signed [VAL_W-1:0] out_target_return_r;
  logic                    out_last_r;

  // store access
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [ROW_BITS-1:0]     wr_data;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic [ROW_BITS-1:0]     rd_data;
  logic [AW-1:0]           count_m1;

  logic signed [VAL_W-1:0] row_reward;
  logic signed [VAL_W-1:0] row_value;
  logic signed [VAL_W-1:0] row_succ;
  logic                    row_term;
  logic                    row_trunc;
  logic signed [VAL_W-1:0] boot;

  logic signed [VAL_W-1:0] mul_a;
  logic [GL_W-1:0]         mul_b;
  logic signed [WIDE_W-1:0] prod;
  logic signed [WIDE_W-1:0] prod_sh;
  logic signed [WIDE_W-1:0] delta_sum;
  logic signed [WIDE_W-1:0] adv_sum;
  logic signed [WIDE_W-1:0] ret_sum;
  logic signed [VAL_W-1:0] adv;
  logic signed [VAL_W-1:0] ret;
  logic signed [VAL_W-1:0] trace_term;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r >= CW'(CAPACITY));
  assign stat.last  = (t_r == '0);

  assign count_m1 = AW'(count_r - CW'(1));
  assign wr_en    = cmd.add_req && !stat.full;
  assign wr_addr  = AW'(count_r);
  assign wr_data  = {in_reward, in_state_value, in_successor_value, in_terminated, in_truncated};
  assign rd_en    = cmd.fin_start || (cmd.emit && !stat.last);
  assign rd_addr  = cmd.fin_start ? count_m1 : (t_r - AW'(1));

  gae_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (CAPACITY),
    .ADDR_W(AW)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign row_reward = rd_data[2 + 2*VAL_W +: VAL_W];
  assign row_value  = rd_data[2 + VAL_W +: VAL_W];
  assign row_succ   = rd_data[2 +: VAL_W];
  assign row_term   = rd_data[1];
  assign row_trunc  = rd_data[0];

  // bootstrap: zero on termination, own successor on truncation, else following row
  assign boot = row_term ? '0 : (row_trunc ? row_succ : next_val_r);

  // one shared multiplier: gamma*lambda at start, then boot*gamma and trace*gl per row
  always_comb begin
    if (cmd.fin_start) begin
      mul_a = $signed(VAL_W'(discount_r));
      mul_b = GL_W'(trace_decay_r);
    end else if (cmd.mul_boot) begin
      mul_a = boot;
      mul_b = GL_W'(discount_r);
    end else begin
      mul_a = trace_acc_r;
      mul_b = gl_r;
    end
  end

  assign prod    = mul_a * $signed({1'b0, mul_b});
  assign prod_sh = prod >>> FRAC_W;

  assign delta_sum  = WIDE_W'(row_reward) + WIDE_W'(sb_r) - WIDE_W'(row_value);
  assign trace_term = (row_term || row_trunc) ? '0 : sg_r;
  assign adv_sum    = WIDE_W'(delta_r) + WIDE_W'(trace_term);
  assign adv        = sat_val(adv_sum);
  assign ret_sum    = WIDE_W'(adv) + WIDE_W'(row_value);
  assign ret        = sat_val(ret_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      discount_r    <= DISCOUNT_RST;
      trace_decay_r <= TRACE_DECAY_RST;
      count_r       <= '0;
      trace_acc_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DISCOUNT:    discount_r    <= cfg_data;
          CFG_TRACE_DECAY: trace_decay_r <= cfg_data;
          default: ;
        endcase
      end
      if (wr_en) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.clear) begin
        count_r <= '0;
      end
      if (cmd.clear || cmd.fin_start || cmd.fin_empty) begin
        trace_acc_r <= '0;
      end else if (cmd.emit) begin
        trace_acc_r <= adv;
      end
      out_valid_r <= cmd.add_req || cmd.fin_empty || cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_start) begin
      gl_r       <= prod_sh[GL_W-1:0];
      t_r        <= count_m1;
      next_val_r <= in_tail_value;
    end
    if (cmd.mul_boot) begin
      sb_r <= sat_val(prod_sh);
    end
    if (cmd.mul_trace) begin
      sg_r    <= sat_val(prod_sh);
      delta_r <= sat_val(delta_sum);
    end
    if (cmd.emit) begin
      next_val_r <= row_value;
      if (!stat.last) begin
        t_r <= t_r - AW'(1);
      end
    end

    if (cmd.add_req) begin
      out_status_r        <= stat.full ? STAT_FULL : STAT_OK;
      out_row_index_r     <= stat.full ? '0 : ROW_W'(wr_addr);
      out_advantage_r     <= '0;
      out_target_return_r <= '0;
      out_last_r          <= 1'b1;
    end else if (cmd.fin_empty) begin
      out_status_r        <= STAT_EMPTY;
      out_row_index_r     <= '0;
      out_advantage_r     <= '0;
      out_target_return_r <= '0;
      out_last_r          <= 1'b1;
    end else if (cmd.emit) begin
      out_status_r        <= STAT_OK;
      out_row_index_r     <= ROW_W'(t_r);
      out_advantage_r     <= adv;
      out_target_return_r <= ret;
      out_last_r          <= stat.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_row_index     = out_row_index_r;
  assign out_advantage     = out_advantage_r;
  assign out_target_return = out_target_return_r;
  assign out_last_in_run   = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("row count beyond capacity");

  a_full_no_growth: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.add_req && stat.full) |=> $stable(count_r))
    else $error("dropped add changed the row count");

endmodule

`default_nettype wire

### design/gae_advantage_engine_top.sv
// top level of the generalized advantage estimation engine
//
// requests enter on start/in_* and are taken at a clock edge with start high
// and busy low. in_kind selects add (store one transition), finish (walk the
// stored rows backward using in_tail_value) or clear (drop all rows).
// results leave on out_* for exactly one cycle, marked by out_valid; the
// receiver cannot stall, so every result must be taken when shown.
// add and an empty finish give one result in the cycle after acceptance and
// leave busy low, so one such request can be taken every cycle. clear gives
// no result. a finish over n rows keeps busy high until its last result is out:
// each row goes through boot scaling and trace scaling, both on the one shared
// 32x18 multiplier, then sum and emit, with one store read per row. row results
// appear last row first; busy falls together with the final result.
// discount and trace_decay are written on the cfg_ channel, always ready; the user
// must write them only while the block is idle, which the block does not enforce.
// reset (rst_n low, synchronous) empties the store, zeroes the trace and
// restores the default discount and trace_decay; no clearing pass is needed.
`default_nettype none

module gae_advantage_engine_top #(
  parameter int CAPACITY = gae_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [gae_pkg::KIND_W-1:0]       in_kind,
  input  logic signed [gae_pkg::VAL_W-1:0] in_reward,
  input  logic signed [gae_pkg::VAL_W-1:0] in_state_value,
  input  logic signed [gae_pkg::VAL_W-1:0] in_successor_value,
  input  logic                             in_terminated,
  input  logic                             in_truncated,
  input  logic signed [gae_pkg::VAL_W-1:0] in_tail_value,
  output logic                             out_valid,
  output logic [gae_pkg::STAT_W-1:0]       out_status,
  output logic [gae_pkg::ROW_W-1:0]        out_row_index,
  output logic signed [gae_pkg::VAL_W-1:0] out_advantage,
  output logic signed [gae_pkg::VAL_W-1:0] out_target_return,
  output logic                             out_last_in_run,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gae_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gae_pkg::FAC_W-1:0]        cfg_data
);

  import gae_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  gae_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_kind(in_kind),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  gae_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_reward         (in_reward),
    .in_state_value    (in_state_value),
    .in_successor_value(in_successor_value),
    .in_terminated     (in_terminated),
    .in_truncated      (in_truncated),
    .in_tail_value     (in_tail_value),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_row_index     (out_row_index),
    .out_advantage     (out_advantage),
    .out_target_return (out_target_return),
    .out_last_in_run   (out_last_in_run)
  );

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_in_run) |-> !busy)
    else $error("still busy after the final result");

  a_mid_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_in_run) |-> busy)
    else $error("walk result shown while idle");

endmodule

`default_nettype wire
